### hw/rtl/bert_basic_pretokenizer_unit_macros.svh
// assertion helpers for the pre-tokenizer
`ifndef BERT_BASIC_PRETOKENIZER_UNIT_MACROS_SVH
`define BERT_BASIC_PRETOKENIZER_UNIT_MACROS_SVH

// clocked check, off while in reset
`define BBPT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked check that also runs during reset
`define BBPT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### hw/rtl/bbpt_pkg.sv
package bbpt_pkg;

  localparam int unsigned CpW     = 21;
  localparam int unsigned Slots   = 4;
  localparam int unsigned NPunct  = 191;

  localparam logic [1:0] CLS_WORD  = 2'd0;
  localparam logic [1:0] CLS_CJK   = 2'd1;
  localparam logic [1:0] CLS_PUNCT = 2'd2;

  typedef enum logic [2:0] {
    K_DROP, K_WHITE, K_CJK, K_PUNCT, K_WORD
  } kind_e;

  typedef logic [CpW-1:0] cp_t;

  // punctuation ranges, {low, high}; is_punct uses only the entries above ascii
  localparam logic [41:0] PUNCT_TAB [NPunct] = '{
    {21'h21,21'h23},{21'h25,21'h2A},{21'h2C,21'h2F},{21'h3A,21'h3B},{21'h3F,21'h40},
    {21'h5B,21'h5D},{21'h5F,21'h5F},{21'h7B,21'h7B},{21'h7D,21'h7D},{21'hA1,21'hA1},
    {21'hA7,21'hA7},{21'hAB,21'hAB},{21'hB6,21'hB7},{21'hBB,21'hBB},{21'hBF,21'hBF},
    {21'h37E,21'h37E},{21'h387,21'h387},{21'h55A,21'h55F},{21'h589,21'h58A},
    {21'h5BE,21'h5BE},{21'h5C0,21'h5C0},{21'h5C3,21'h5C3},{21'h5C6,21'h5C6},
    {21'h5F3,21'h5F4},{21'h609,21'h60A},{21'h60C,21'h60D},{21'h61B,21'h61B},
    {21'h61D,21'h61F},{21'h66A,21'h66D},{21'h6D4,21'h6D4},{21'h700,21'h70D},
    {21'h7F7,21'h7F9},{21'h830,21'h83E},{21'h85E,21'h85E},{21'h964,21'h965},
    {21'h970,21'h970},{21'h9FD,21'h9FD},{21'hA76,21'hA76},{21'hAF0,21'hAF0},
    {21'hC77,21'hC77},{21'hC84,21'hC84},{21'hDF4,21'hDF4},{21'hE4F,21'hE4F},
    {21'hE5A,21'hE5B},{21'hF04,21'hF12},{21'hF14,21'hF14},{21'hF3A,21'hF3D},
    {21'hF85,21'hF85},{21'hFD0,21'hFD4},{21'hFD9,21'hFDA},{21'h104A,21'h104F},
    {21'h10FB,21'h10FB},{21'h1360,21'h1368},{21'h1400,21'h1400},{21'h166E,21'h166E},
    {21'h169B,21'h169C},{21'h16EB,21'h16ED},{21'h1735,21'h1736},{21'h17D4,21'h17D6},
    {21'h17D8,21'h17DA},{21'h1800,21'h180A},{21'h1944,21'h1945},{21'h1A1E,21'h1A1F},
    {21'h1AA0,21'h1AA6},{21'h1AA8,21'h1AAD},{21'h1B5A,21'h1B60},{21'h1B7D,21'h1B7E},
    {21'h1BFC,21'h1BFF},{21'h1C3B,21'h1C3F},{21'h1C7E,21'h1C7F},{21'h1CC0,21'h1CC7},
    {21'h1CD3,21'h1CD3},{21'h2010,21'h2027},{21'h2030,21'h2043},{21'h2045,21'h2051},
    {21'h2053,21'h205E},{21'h207D,21'h207E},{21'h208D,21'h208E},{21'h2308,21'h230B},
    {21'h2329,21'h232A},{21'h2768,21'h2775},{21'h27C5,21'h27C6},{21'h27E6,21'h27EF},
    {21'h2983,21'h2998},{21'h29D8,21'h29DB},{21'h29FC,21'h29FD},{21'h2CF9,21'h2CFC},
    {21'h2CFE,21'h2CFF},{21'h2D70,21'h2D70},{21'h2E00,21'h2E2E},{21'h2E30,21'h2E4F},
    {21'h2E52,21'h2E5D},{21'h3001,21'h3003},{21'h3008,21'h3011},{21'h3014,21'h301F},
    {21'h3030,21'h3030},{21'h303D,21'h303D},{21'h30A0,21'h30A0},{21'h30FB,21'h30FB},
    {21'hA4FE,21'hA4FF},{21'hA60D,21'hA60F},{21'hA673,21'hA673},{21'hA67E,21'hA67E},
    {21'hA6F2,21'hA6F7},{21'hA874,21'hA877},{21'hA8CE,21'hA8CF},{21'hA8F8,21'hA8FA},
    {21'hA8FC,21'hA8FC},{21'hA92E,21'hA92F},{21'hA95F,21'hA95F},{21'hA9C1,21'hA9CD},
    {21'hA9DE,21'hA9DF},{21'hAA5C,21'hAA5F},{21'hAADE,21'hAADF},{21'hAAF0,21'hAAF1},
    {21'hABEB,21'hABEB},{21'hFD3E,21'hFD3F},{21'hFE10,21'hFE19},{21'hFE30,21'hFE52},
    {21'hFE54,21'hFE61},{21'hFE63,21'hFE63},{21'hFE68,21'hFE68},{21'hFE6A,21'hFE6B},
    {21'hFF01,21'hFF03},{21'hFF05,21'hFF0A},{21'hFF0C,21'hFF0F},{21'hFF1A,21'hFF1B},
    {21'hFF1F,21'hFF20},{21'hFF3B,21'hFF3D},{21'hFF3F,21'hFF3F},{21'hFF5B,21'hFF5B},
    {21'hFF5D,21'hFF5D},{21'hFF5F,21'hFF65},{21'h10100,21'h10102},{21'h1039F,21'h1039F},
    {21'h103D0,21'h103D0},{21'h1056F,21'h1056F},{21'h10857,21'h10857},
    {21'h1091F,21'h1091F},{21'h1093F,21'h1093F},{21'h10A50,21'h10A58},
    {21'h10A7F,21'h10A7F},{21'h10AF0,21'h10AF6},{21'h10B39,21'h10B3F},
    {21'h10B99,21'h10B9C},{21'h10EAD,21'h10EAD},{21'h10F55,21'h10F59},
    {21'h10F86,21'h10F89},{21'h11047,21'h1104D},{21'h110BB,21'h110BC},
    {21'h110BE,21'h110C1},{21'h11140,21'h11143},{21'h11174,21'h11175},
    {21'h111C5,21'h111C8},{21'h111CD,21'h111CD},{21'h111DB,21'h111DB},
    {21'h111DD,21'h111DF},{21'h11238,21'h1123D},{21'h112A9,21'h112A9},
    {21'h1144B,21'h1144F},{21'h1145A,21'h1145B},{21'h1145D,21'h1145D},
    {21'h114C6,21'h114C6},{21'h115C1,21'h115D7},{21'h11641,21'h11643},
    {21'h11660,21'h1166C},{21'h116B9,21'h116B9},{21'h1173C,21'h1173E},
    {21'h1183B,21'h1183B},{21'h11944,21'h11946},{21'h119E2,21'h119E2},
    {21'h11A3F,21'h11A46},{21'h11A9A,21'h11A9C},{21'h11A9E,21'h11AA2},
    {21'h11B00,21'h11B09},{21'h11C41,21'h11C45},{21'h11C70,21'h11C71},
    {21'h11EF7,21'h11EF8},{21'h11F43,21'h11F4F},{21'h11FFF,21'h11FFF},
    {21'h12470,21'h12474},{21'h12FF1,21'h12FF2},{21'h16A6E,21'h16A6F},
    {21'h16AF5,21'h16AF5},{21'h16B37,21'h16B3B},{21'h16B44,21'h16B44},
    {21'h16E97,21'h16E9A},{21'h16FE2,21'h16FE2},{21'h1BC9F,21'h1BC9F},
    {21'h1DA87,21'h1DA8B},{21'h1E95E,21'h1E95F}
  };

  function automatic logic in_rng(cp_t c, cp_t lo, cp_t hi);
    return (c >= lo) && (c <= hi);
  endfunction

  function automatic logic is_white(cp_t c);
    return c == 21'h09 || c == 21'h0A || c == 21'h0D || c == 21'h20 || c == 21'hA0 ||
           c == 21'h1680 || c == 21'h202F || c == 21'h205F || c == 21'h3000 ||
           in_rng(c, 21'h2000, 21'h200A);
  endfunction

  function automatic logic is_ctrl(cp_t c);
    logic tab;
    tab = c == 21'h09 || c == 21'h0A || c == 21'h0D;
    return !tab && (c < 21'h20 || c == 21'h7F || in_rng(c, 21'h80, 21'h9F) ||
           c == 21'hAD || in_rng(c, 21'h200B, 21'h200F) || in_rng(c, 21'h202A, 21'h202E) ||
           in_rng(c, 21'h2060, 21'h2064) || in_rng(c, 21'h2066, 21'h206F) ||
           c == 21'hFEFF);
  endfunction

  function automatic logic is_cjk(cp_t c);
    return in_rng(c, 21'h4E00, 21'h9FFF) || in_rng(c, 21'h3400, 21'h4DBF) ||
           in_rng(c, 21'h20000, 21'h2A6DF) || in_rng(c, 21'h2A700, 21'h2B73F) ||
           in_rng(c, 21'h2B740, 21'h2B81F) || in_rng(c, 21'h2B820, 21'h2CEAF) ||
           in_rng(c, 21'hF900, 21'hFAFF) || in_rng(c, 21'h2F800, 21'h2FA1F);
  endfunction

  // ascii ranges plus a parallel compare against every table range
  function automatic logic is_punct(cp_t c);
    logic hit;
    hit = in_rng(c, 21'd33, 21'd47) || in_rng(c, 21'd58, 21'd64) ||
          in_rng(c, 21'd91, 21'd96) || in_rng(c, 21'd123, 21'd126);
    for (int i = 0; i < NPunct; i++) begin
      if (c > 21'd127 && in_rng(c, PUNCT_TAB[i][41:21], PUNCT_TAB[i][20:0])) hit = 1'b1;
    end
    return hit;
  endfunction

  function automatic kind_e classify(cp_t c);
    kind_e k;
    if (c == '0 || c == 21'hFFFD || is_ctrl(c)) k = K_DROP;
    else if (is_white(c)) k = K_WHITE;
    else if (is_cjk(c)) k = K_CJK;
    else if (is_punct(c)) k = K_PUNCT;
    else k = K_WORD;
    return k;
  endfunction

endpackage

### hw/rtl/bert_basic_pretokenizer_unit.sv
// Streaming pre-tokenizer: UTF-8 bytes in, classified code points out.
// Input channel: text_valid_i / text_stall_o carry text_byte_i and last_byte_i,
// one byte per request; last_byte_i marks the end of a text.
// Output channel: tok_valid_o / tok_stall_i carry one code point per request
// with its class, token start, has_char, end_of_text and last_of_run flags.
// Configuration: cfg_we_i writes cfg_wdata_i into lower_case (reset 1).
// Each byte passes through the decode register, then is classified into the
// result buffer.
// Throughput: one byte per cycle while each byte gives at most one result and
// the output is not stalled; a byte that gives more results holds the input
// while the result buffer drains one entry per cycle through the unstalled output port.
// A stalled output keeps its request steady; the decode register still takes
// a byte, after which the input stalls until the buffer frees.
// Reset clears the decoder state bar held bytes, the token state and both
// pipeline valid flags and sets lower_case; nothing is pending afterwards.
`include "bert_basic_pretokenizer_unit_macros.svh"

module bert_basic_pretokenizer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        text_valid_i,
  output logic        text_stall_o,
  input  logic [7:0]  text_byte_i,
  input  logic        last_byte_i,
  output logic        tok_valid_o,
  input  logic        tok_stall_i,
  output logic [20:0] code_point_o,
  output logic [1:0]  char_class_o,
  output logic        starts_token_o,
  output logic        has_char_o,
  output logic        end_of_text_o,
  output logic        last_of_run_o
);

  localparam int unsigned NS = bbpt_pkg::Slots;

  logic lower_case_q;

  // decoder state
  logic [7:0]  lead_q, lead_d;
  logic [2:0]  exp_q, exp_d;
  logic [1:0]  seen_q, seen_d;
  logic [20:0] part_q, part_d;
  logic [7:0]  held_q [3];
  logic        held_we;

  // decode register
  logic              s1_valid_q;
  bbpt_pkg::cp_t     s1_cp_q [NS];
  bbpt_pkg::cp_t     s1_cp_d [NS];
  logic [NS-1:0]     s1_msk_q, s1_msk_d;
  logic              s1_last_q;

  // result buffer
  bbpt_pkg::cp_t     s2_cp_q [NS];
  bbpt_pkg::cp_t     s2_cp_d [NS];
  logic [1:0]        s2_cls_q [NS];
  logic [1:0]        s2_cls_d [NS];
  logic [NS-1:0]     s2_st_q, s2_st_d, s2_hc_q, s2_hc_d, s2_msk_q, s2_msk_d;
  logic              s2_last_q;
  logic              tok_open_q, tok_open_d;

  logic          in_fire, out_fire, s2_free, s1_move, one_left;
  logic [NS-1:0] sel;
  logic [1:0]    sel_idx;

  // handshake
  assign tok_valid_o  = |s2_msk_q;
  assign one_left     = (s2_msk_q & (s2_msk_q - 1'b1)) == '0;
  assign out_fire     = tok_valid_o && !tok_stall_i;
  assign s2_free      = !tok_valid_o || (out_fire && one_left);
  assign s1_move      = s1_valid_q && s2_free;
  assign text_stall_o = s1_valid_q && !s2_free;
  assign in_fire      = text_valid_i && !text_stall_o;

  // utf-8 decode of the incoming byte
  always_comb begin
    logic pend, cont, brk, done;
    pend    = exp_q != 3'd0;
    cont    = text_byte_i[7:6] == 2'b10;
    brk     = 1'b0;
    done    = 1'b0;
    held_we = 1'b0;
    lead_d  = lead_q;
    exp_d   = exp_q;
    seen_d  = seen_q;
    part_d  = part_q;
    s1_msk_d = '0;
    s1_cp_d[0] = {13'd0, lead_q};
    s1_cp_d[1] = {13'd0, held_q[0]};
    s1_cp_d[2] = {13'd0, held_q[1]};
    s1_cp_d[3] = {13'd0, text_byte_i};
    if (pend && cont && ({1'b0, seen_q} + 3'd2 == exp_q)) begin
      s1_cp_d[3]  = {part_q[14:0], text_byte_i[5:0]};
      s1_msk_d[3] = 1'b1;
      done        = 1'b1;
    end else if (pend && cont && (last_byte_i || seen_q >= 2'd2)) begin
      brk         = 1'b1;
      s1_msk_d[3] = 1'b1;
      done        = 1'b1;
    end else if (pend && cont) begin
      held_we = 1'b1;
      seen_d  = seen_q + 2'd1;
      part_d  = {part_q[14:0], text_byte_i[5:0]};
    end else begin
      brk = pend;
      if (text_byte_i >= 8'hC0 && !last_byte_i) begin
        lead_d = text_byte_i;
        seen_d = 2'd0;
        if (text_byte_i >= 8'hF0) begin
          exp_d  = 3'd4;
          part_d = {18'd0, text_byte_i[2:0]};
        end else if (text_byte_i >= 8'hE0) begin
          exp_d  = 3'd3;
          part_d = {17'd0, text_byte_i[3:0]};
        end else begin
          exp_d  = 3'd2;
          part_d = {16'd0, text_byte_i[4:0]};
        end
      end else begin
        s1_msk_d[3] = 1'b1;
        done        = 1'b1;
      end
    end
    if (brk) begin
      s1_msk_d[0] = 1'b1;
      s1_msk_d[1] = seen_q >= 2'd1;
      s1_msk_d[2] = seen_q >= 2'd2;
    end
    if (done) begin
      lead_d = '0;
      exp_d  = '0;
      seen_d = '0;
      part_d = '0;
    end
  end

  // classify the decoded candidates and chain the token state
  always_comb begin
    bbpt_pkg::kind_e k;
    logic            open;
    open     = tok_open_q;
    s2_msk_d = '0;
    s2_st_d  = '0;
    s2_hc_d  = '0;
    for (int i = 0; i < NS; i++) begin
      s2_cp_d[i]  = s1_cp_q[i];
      s2_cls_d[i] = bbpt_pkg::CLS_WORD;
      k = bbpt_pkg::classify(s1_cp_q[i]);
      if (s1_msk_q[i]) begin
        case (k)
          bbpt_pkg::K_WHITE: open = 1'b0;
          bbpt_pkg::K_CJK: begin
            s2_msk_d[i] = 1'b1;
            s2_hc_d[i]  = 1'b1;
            s2_st_d[i]  = 1'b1;
            s2_cls_d[i] = bbpt_pkg::CLS_CJK;
            open        = 1'b0;
          end
          bbpt_pkg::K_PUNCT: begin
            s2_msk_d[i] = 1'b1;
            s2_hc_d[i]  = 1'b1;
            s2_st_d[i]  = 1'b1;
            s2_cls_d[i] = bbpt_pkg::CLS_PUNCT;
            open        = 1'b0;
          end
          bbpt_pkg::K_WORD: begin
            s2_msk_d[i] = 1'b1;
            s2_hc_d[i]  = 1'b1;
            s2_st_d[i]  = !open;
            if (lower_case_q && s1_cp_q[i] >= 21'h41 && s1_cp_q[i] <= 21'h5A) begin
              s2_cp_d[i] = s1_cp_q[i] | 21'h20;
            end
            open = 1'b1;
          end
          default: ;
        endcase
      end
    end
    // bare end marker when the last byte kept nothing
    if (s1_last_q && s2_msk_d == '0) begin
      s2_msk_d[NS-1] = 1'b1;
      s2_cp_d[NS-1]  = '0;
      s2_cls_d[NS-1] = bbpt_pkg::CLS_WORD;
    end
    tok_open_d = s1_last_q ? 1'b0 : open;
  end

  // pick the oldest remaining result
  always_comb begin
    sel_idx = '0;
    for (int i = NS - 1; i >= 0; i--) begin
      if (s2_msk_q[i]) sel_idx = 2'(i);
    end
    sel = '0;
    sel[sel_idx] = 1'b1;
  end

  assign code_point_o   = s2_cp_q[sel_idx];
  assign char_class_o   = s2_cls_q[sel_idx];
  assign starts_token_o = s2_st_q[sel_idx];
  assign has_char_o     = s2_hc_q[sel_idx];
  assign end_of_text_o  = s2_last_q && one_left;
  assign last_of_run_o  = one_left;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lower_case_q <= 1'b1;
      lead_q       <= '0;
      exp_q        <= '0;
      seen_q       <= '0;
      part_q       <= '0;
      s1_valid_q   <= 1'b0;
      s2_msk_q     <= '0;
      tok_open_q   <= 1'b0;
    end else begin
      if (cfg_we_i) lower_case_q <= cfg_wdata_i;
      if (in_fire) begin
        lead_q <= lead_d;
        exp_q  <= exp_d;
        seen_q <= seen_d;
        part_q <= part_d;
      end
      if (in_fire) s1_valid_q <= 1'b1;
      else if (s1_move) s1_valid_q <= 1'b0;
      if (s1_move) begin
        s2_msk_q   <= s2_msk_d;
        tok_open_q <= tok_open_d;
      end else if (out_fire) begin
        s2_msk_q <= s2_msk_q & ~sel;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire && held_we) held_q[seen_q] <= text_byte_i;
    if (in_fire) begin
      s1_cp_q   <= s1_cp_d;
      s1_msk_q  <= s1_msk_d;
      s1_last_q <= last_byte_i;
    end
    if (s1_move) begin
      s2_cp_q   <= s2_cp_d;
      s2_cls_q  <= s2_cls_d;
      s2_st_q   <= s2_st_d;
      s2_hc_q   <= s2_hc_d;
      s2_last_q <= s1_last_q;
    end
  end

  `BBPT_ASSERT(a_stall_full, text_stall_o |-> s1_valid_q && tok_valid_o, "stall while empty")
  `BBPT_ASSERT(a_buf_hold, tok_valid_o && tok_stall_i |=> $stable(s2_msk_q), "buffer changed")
  `BBPT_ASSERT(a_marker, tok_valid_o && !has_char_o |-> end_of_text_o && last_of_run_o, "bad marker")
  `BBPT_ASSERT(a_seen_rng, seen_q <= 2'd2 && exp_q <= 3'd4, "decoder state out of range")

endmodule
